// ----- src/sgap_pkg.sv -----
// ----------------------------------------------------------------------------
// sgap_pkg
// Shared types for the sequence gap emitter: the flags that travel with each
// emit command from the classifier to the emitter.
// ----------------------------------------------------------------------------
package sgap_pkg;

  // flags attached to one emit command
  typedef struct packed {
    logic truncated;     // gap was longer than the run limit
    logic out_of_order;  // input fell below the expected value
  } gap_flags_t;

  localparam int unsigned FLAGS_W = $bits(gap_flags_t);

endpackage

// ----- src/sgap_front.sv -----
// ----------------------------------------------------------------------------
// sgap_front
// Accepts input requests, tracks the next expected value and turns every
// request that needs results into one emit command (base, count, flags).
// ----------------------------------------------------------------------------
module sgap_front #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_RUN     = 64,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [31:0]             value,
  input  logic                    start_req,
  output logic                    cmd_push,
  input  logic                    cmd_full,
  output logic [VALUE_WIDTH-1:0]  cmd_base,
  output logic [CNT_W-1:0]        cmd_count,
  output sgap_pkg::gap_flags_t    cmd_flags
);
  import sgap_pkg::*;

  localparam logic [VALUE_WIDTH:0] RUN_LIM = (VALUE_WIDTH + 1)'(MAX_RUN);

  logic [VALUE_WIDTH:0] expected_next;
  logic                 sequence_open;

  logic [VALUE_WIDTH:0] v_ext;
  logic [VALUE_WIDTH:0] gap;
  logic                 restart;
  logic                 below;
  logic                 big;
  logic                 has_result;
  logic                 accept;

  // classify the incoming request
  always_comb begin
    v_ext      = {1'b0, VALUE_WIDTH'(value)};
    restart    = start_req || !sequence_open;
    below      = v_ext < expected_next;
    gap        = v_ext - expected_next;
    big        = gap > RUN_LIM;
    has_result = !restart && (below || (gap != '0));
  end

  // command toward the emitter
  always_comb begin
    if (below) begin
      cmd_base  = v_ext[VALUE_WIDTH-1:0];
      cmd_count = CNT_W'(1);
    end else begin
      cmd_base  = expected_next[VALUE_WIDTH-1:0];
      cmd_count = big ? CNT_W'(MAX_RUN) : gap[CNT_W-1:0];
    end
    cmd_flags.truncated    = !below && big;
    cmd_flags.out_of_order = below;
  end

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept && has_result;

  // expectation state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_next <= '0;
      sequence_open <= 1'b0;
    end else if (accept) begin
      if (restart) begin
        expected_next <= v_ext + 1'b1;
        sequence_open <= 1'b1;
      end else if (!below) begin
        expected_next <= v_ext + 1'b1;
      end
    end
  end

endmodule

// ----- src/sgap_queue.sv -----
// ----------------------------------------------------------------------------
// sgap_queue
// Two-entry command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module sgap_queue #(
  parameter int unsigned DATA_W = 41
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- src/sgap_back.sv -----
// ----------------------------------------------------------------------------
// sgap_back
// Emitter: takes one command at a time and counts out its results, one per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sgap_back #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_avail,
  output logic                    cmd_pop,
  input  logic [VALUE_WIDTH-1:0]  cmd_base,
  input  logic [CNT_W-1:0]        cmd_count,
  input  sgap_pkg::gap_flags_t    cmd_flags,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             missing_value,
  output logic                    last,
  output logic                    gap_truncated,
  output logic                    out_of_order
);
  import sgap_pkg::*;

  logic                   active;
  logic [VALUE_WIDTH-1:0] cur;
  logic [CNT_W-1:0]       left;
  gap_flags_t             flags;
  logic                   load_out;
  logic                   final_one;

  assign final_one = left == CNT_W'(1);
  assign load_out  = active && (!out_valid || out_ready);
  assign cmd_pop   = cmd_avail && (!active || (load_out && final_one));

  // command walk
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd_pop) begin
      active <= 1'b1;
    end else if (load_out && final_one) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd_base;
      left  <= cmd_count;
      flags <= cmd_flags;
    end else if (load_out) begin
      cur  <= cur + 1'b1;
      left <= left - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      missing_value <= 32'(cur);
      last          <= final_one;
      gap_truncated <= flags.truncated && final_one;
      out_of_order  <= flags.out_of_order;
    end
  end

endmodule

// ----- src/sorted_sequence_gap_emitter_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_sequence_gap_emitter_unit
// Reports values skipped in an ascending stream of sequence numbers.
// ----------------------------------------------------------------------------
// An input request that starts a sequence, or carries the expected value, is
// taken and gives no result, so such requests flow at one per cycle while
// the command queue has room. A request that jumps ahead gives
// min(gap, MAX_RUN) results and one that falls below the expected value gives
// a single out-of-order result; the emitter counts results out at one per
// cycle while out_ready does not stall the output. A two-entry command queue
// lets the input side run up to two result-producing requests ahead of the
// command being emitted; once it is full, in_ready drops for every request
// until the emitter takes the next command. A result passes from the command
// queue through the emitter's command registers and then the output register.
module sorted_sequence_gap_emitter_unit #(
  parameter int unsigned MAX_RUN     = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] missing_value,
  output logic        last,
  output logic        gap_truncated,
  output logic        out_of_order
);
  import sgap_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned DATA_W = VALUE_WIDTH + CNT_W + FLAGS_W;

  logic                   cmd_push;
  logic                   cmd_full;
  logic [VALUE_WIDTH-1:0] f_base;
  logic [CNT_W-1:0]       f_count;
  gap_flags_t             f_flags;

  logic                   cmd_pop;
  logic                   cmd_avail;
  logic [DATA_W-1:0]      q_out;
  logic [VALUE_WIDTH-1:0] b_base;
  logic [CNT_W-1:0]       b_count;
  gap_flags_t             b_flags;

  // classifier
  sgap_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_RUN     (MAX_RUN),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .start_req (start_req),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full),
    .cmd_base  (f_base),
    .cmd_count (f_count),
    .cmd_flags (f_flags)
  );

  // command queue
  sgap_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data ({f_base, f_count, f_flags}),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_avail),
    .pop_data  (q_out)
  );

  assign {b_base, b_count, b_flags} = q_out;

  // emitter
  sgap_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_avail     (cmd_avail),
    .cmd_pop       (cmd_pop),
    .cmd_base      (b_base),
    .cmd_count     (b_count),
    .cmd_flags     (b_flags),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .missing_value (missing_value),
    .last          (last),
    .gap_truncated (gap_truncated),
    .out_of_order  (out_of_order)
  );

  // a queued command always carries between one and MAX_RUN results
  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (f_count != '0) && (f_count <= CNT_W'(MAX_RUN)))
    else $error("emit command with bad count");

  // an out-of-order result stands alone and is never truncated
  a_ooo_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_order |-> last && !gap_truncated)
    else $error("out-of-order result not single");

  // truncation is marked only on the final result of a run
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && gap_truncated |-> last)
    else $error("truncation flag before end of run");

endmodule

// ----- test/tb_sorted_sequence_gap_emitter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_sequence_gap_emitter_unit
// Drives ascending sequence numbers into the gap emitter with random idle
// cycles on both handshakes. The expected missing values come from a
// predictor of the gap rules. A short table of directed requests covers
// starts, duplicates, descents, exact and truncated gaps and the top of the
// value range. After it comes a stream of mostly well-formed random sequences.
// ----------------------------------------------------------------------------
module tb_sorted_sequence_gap_emitter_unit;
  import sgap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_RUN      = 64;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam logic [63:0] VALUE_MASK   = (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam int unsigned RANDOM_REQS  = 200;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 12_000_000;

  // one result as seen on the output port
  typedef struct packed {
    logic [31:0] missing;
    logic        last;
    gap_flags_t  flags;
  } gap_result_t;

  // how a directed row gets its expected results
  typedef enum {
    EXP_MODEL,       // taken from the predictor
    EXP_NONE,        // no result at all
    EXP_ORDER_ERR,   // single out-of-order result carrying the value
    EXP_SINGLE_GAP   // single missing value, just below the request
  } row_exp_e;

  typedef struct {
    logic [31:0] v;
    logic        s;
    row_exp_e    kind;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] value;
  logic        start_req;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] missing_value;
  logic        last;
  logic        gap_truncated;
  logic        out_of_order;

  // predictor state
  logic [63:0] next_seq;
  logic        seq_open;

  gap_result_t step_res[$];
  gap_result_t pending_gaps[$];
  dir_row_t    dir_rows[$];
  int unsigned err_count = 0;
  logic        in_quiet  = 1'b0;
  logic        out_quiet = 1'b0;

  sorted_sequence_gap_emitter_unit #(
    .MAX_RUN    (MAX_RUN),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .start_req    (start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .missing_value(missing_value),
    .last         (last),
    .gap_truncated(gap_truncated),
    .out_of_order (out_of_order)
  );

  always #6 clk = ~clk;

  // gap predictor: updates the sequence state, leaves results in step_res
  task automatic predict_gaps(input logic [31:0] v_in, input logic s);
    logic [63:0] v;
    logic [63:0] gap;
    logic [63:0] n;
    logic [63:0] i;
    gap_result_t r;
    step_res.delete();
    v = {32'b0, v_in} & VALUE_MASK;
    if (s || !seq_open) begin
      next_seq = v + 64'd1;
      seq_open = 1'b1;
    end else if (v < next_seq) begin
      r.missing            = v[31:0];
      r.last               = 1'b1;
      r.flags.truncated    = 1'b0;
      r.flags.out_of_order = 1'b1;
      step_res.push_back(r);
    end else begin
      gap = v - next_seq;
      n   = (gap > MAX_RUN) ? 64'(MAX_RUN) : gap;
      for (i = 0; i < n; i++) begin
        r.missing            = next_seq[31:0] + i[31:0];
        r.last               = (i + 1 == n);
        r.flags.truncated    = (i + 1 == n) && (gap > MAX_RUN);
        r.flags.out_of_order = 1'b0;
        step_res.push_back(r);
      end
      next_seq = v + 64'd1;
    end
  endtask

  function automatic void add_row(logic [31:0] v, logic s, row_exp_e kind);
    dir_row_t row;
    row.v    = v;
    row.s    = s;
    row.kind = kind;
    dir_rows.push_back(row);
  endfunction

  // one input request: idle gap, then hold until accepted, then predict
  task automatic send_request(input logic [31:0] v, input logic s, input bit use_model);
    int unsigned idle;
    if ($urandom_range(0, 31) == 0) in_quiet = !in_quiet;
    idle = in_quiet ? 0 : $urandom_range(0, 14);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    start_req <= s;
    do @(posedge clk); while (!in_ready);
    predict_gaps(v, s);
    if (use_model) begin
      foreach (step_res[j]) pending_gaps.push_back(step_res[j]);
    end
  endtask

  // random request, mostly continuing the open sequence
  task automatic draw_request(output logic [31:0] v, output logic s);
    int unsigned pick;
    logic [63:0] cand;
    pick = $urandom_range(0, 99);
    s    = 1'b0;
    if (pick < 8) begin
      s = 1'b1;
      if ($urandom_range(0, 3) == 0) cand = 64'hFFFF_FFFF - $urandom_range(0, 80);
      else cand = {32'b0, $urandom};
    end else if (pick < 45) begin
      cand = next_seq;
    end else if (pick < 75) begin
      cand = next_seq + $urandom_range(1, 8);
    end else if (pick < 85) begin
      cand = next_seq + $urandom_range(9, 80);
    end else if (pick < 88) begin
      cand = next_seq + {32'b0, $urandom};
    end else if (pick < 96) begin
      cand = next_seq - 64'd1 - $urandom_range(0, 5);
    end else begin
      s    = 1'($urandom_range(0, 1));
      cand = {32'b0, $urandom};
    end
    // past the top of the value range: open a fresh sequence instead
    if (cand > VALUE_MASK) begin
      s    = 1'b1;
      cand = {32'b0, $urandom};
    end
    v = cand[31:0];
  endtask

  // result checker
  always @(posedge clk) begin
    gap_result_t want;
    gap_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.missing            = missing_value;
      got.last               = last;
      got.flags.truncated    = gap_truncated;
      got.flags.out_of_order = out_of_order;
      if (pending_gaps.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: value %h last %b trunc %b ooo %b",
                   got.missing, got.last, got.flags.truncated, got.flags.out_of_order);
      end else begin
        want = pending_gaps.pop_front();
        if (got.missing !== want.missing || got.last !== want.last ||
            got.flags.truncated !== want.flags.truncated ||
            got.flags.out_of_order !== want.flags.out_of_order) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: exp value %h last %b trunc %b ooo %b, got %h %b %b %b",
                     want.missing, want.last, want.flags.truncated,
                     want.flags.out_of_order, got.missing, got.last,
                     got.flags.truncated, got.flags.out_of_order);
        end
      end
    end
  end

  // output side stalls
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    logic [31:0] rv;
    logic        rs;
    gap_result_t r;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    start_req <= 1'b0;
    next_seq  = '0;
    seq_open  = 1'b0;

    // value with no sequence open, then expected, gaps, duplicates, descents
    add_row(32'd5, 1'b0, EXP_NONE);
    add_row(32'd6, 1'b0, EXP_NONE);
    add_row(32'd8, 1'b0, EXP_SINGLE_GAP);
    add_row(32'd8, 1'b0, EXP_ORDER_ERR);
    add_row(32'd3, 1'b0, EXP_ORDER_ERR);
    add_row(32'd2, 1'b1, EXP_NONE);
    add_row(32'd14, 1'b0, EXP_MODEL);
    // gap of exactly the run limit, then one past it
    add_row(32'd79, 1'b0, EXP_MODEL);
    add_row(32'd145, 1'b0, EXP_MODEL);
    add_row(32'd0, 1'b1, EXP_NONE);
    add_row(32'd0, 1'b0, EXP_ORDER_ERR);
    // top of the value range: everything afterwards is out of order
    add_row(32'hFFFF_FFFE, 1'b1, EXP_NONE);
    add_row(32'hFFFF_FFFF, 1'b0, EXP_NONE);
    add_row(32'hFFFF_FFFF, 1'b0, EXP_ORDER_ERR);
    add_row(32'd0, 1'b0, EXP_ORDER_ERR);
    // widest possible gap
    add_row(32'd0, 1'b1, EXP_NONE);
    add_row(32'hFFFF_FFFF, 1'b0, EXP_MODEL);
    add_row(32'h5555_5555, 1'b1, EXP_NONE);
    add_row(32'h5555_5557, 1'b0, EXP_SINGLE_GAP);
    add_row(32'hAAAA_AAAA, 1'b0, EXP_MODEL);
    add_row(32'hAAAA_AAAC, 1'b0, EXP_SINGLE_GAP);
    add_row(32'd1, 1'b0, EXP_ORDER_ERR);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].v, dir_rows[k].s, dir_rows[k].kind == EXP_MODEL);
      r.last               = 1'b1;
      r.flags.truncated    = 1'b0;
      r.flags.out_of_order = 1'b0;
      case (dir_rows[k].kind)
        EXP_ORDER_ERR: begin
          r.missing            = dir_rows[k].v;
          r.flags.out_of_order = 1'b1;
          pending_gaps.push_back(r);
        end
        EXP_SINGLE_GAP: begin
          r.missing = dir_rows[k].v - 32'd1;
          pending_gaps.push_back(r);
        end
        default: ;
      endcase
    end

    // random sequences
    for (int n = 0; n < RANDOM_REQS; n++) begin
      draw_request(rv, rs);
      send_request(rv, rs, 1'b1);
    end
    in_valid <= 1'b0;

    while (pending_gaps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
